@@ src/rp2d_pkg.sv @@
// Package for the 7-bit repacking 2D parity encoder.
// Holds the code word type, the per-byte result batch and the row helper.
// No dependencies.
package rp2d_pkg;

   localparam int ROW_BITS = 7;
   localparam int MAX_RESULTS = 3;
   localparam logic [2:0] ROWS_PER_BLOCK = 3'd7;
   localparam logic [2:0] LAST_PHASE = 3'd6;

   typedef logic [ROW_BITS-1:0] row_type;
   typedef logic [ROW_BITS:0] word_type;
   typedef logic [1:0] count_type;

   typedef struct packed {
      word_type [MAX_RESULTS-1:0] words;
      logic [MAX_RESULTS-1:0] parity;
      count_type count;
   } batch_type;

   function automatic word_type make_word(input row_type row);
      return {row, ^row};
   endfunction

endpackage

@@ src/rp2d_chan_if.sv @@
// Handshake channel interfaces for the encoder: data byte in, code word out.
// No dependencies.
interface rp2d_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface rp2d_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] code_word;
   logic is_parity_row;
   logic last_of_run;

   modport source (output valid, output code_word, output is_parity_row,
                   output last_of_run, input ready);
   modport sink (input valid, input code_word, input is_parity_row,
                 input last_of_run, output ready);
endinterface

@@ src/rp2d_row_encoder.sv @@
// Row encoder: repacks bytes into 7-bit rows, adds row and column parity.
// Holds the stream state; depends on rp2d_pkg.
module rp2d_row_encoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic [7:0]         data_byte,
   output rp2d_pkg::batch_type batch
);
   import rp2d_pkg::*;

   row_type    residue_ff, residue_in;
   logic [2:0] phase_ff, phase_in;
   logic [2:0] row_ff, row_in;
   row_type    acc_ff, acc_in;

   logic [2:0]  nbits;
   logic [3:0]  shift_amt;
   row_type     keep_mask, next_mask;
   logic [13:0] pool;
   logic [13:0] shifted;
   row_type     row_a, row_b;
   logic        two_rows;

   always_comb begin
      nbits = (phase_ff > LAST_PHASE) ? LAST_PHASE : phase_ff;
      shift_amt = {1'b0, nbits} + 4'd1;
      keep_mask = 7'((8'd1 << nbits) - 8'd1);
      next_mask = 7'((8'd1 << shift_amt) - 8'd1);
      pool = {residue_ff[5:0] & keep_mask[5:0], data_byte};
      shifted = pool >> shift_amt;
      row_a = shifted[6:0];
      row_b = pool[6:0];
      two_rows = (nbits == LAST_PHASE);
   end

   always_comb begin
      row_type    acc;
      logic [2:0] idx;
      count_type  k;
      acc = acc_ff ^ row_a;
      idx = row_ff + 3'd1;
      batch.words = '0;
      batch.parity = '0;
      batch.words[0] = make_word(row_a);
      k = 2'd1;
      if (idx == ROWS_PER_BLOCK) begin
         batch.words[1] = make_word(acc);
         batch.parity[1] = 1'b1;
         k = 2'd2;
         acc = '0;
         idx = '0;
      end
      if (two_rows) begin
         batch.words[k] = make_word(row_b);
         k = k + 2'd1;
         acc = acc ^ row_b;
         idx = idx + 3'd1;
         if (idx == ROWS_PER_BLOCK) begin
            batch.words[k] = make_word(acc);
            batch.parity[k] = 1'b1;
            k = k + 2'd1;
            acc = '0;
            idx = '0;
         end
      end
      batch.count = k;
      acc_in = acc;
      row_in = idx;
      phase_in = two_rows ? 3'd0 : shift_amt[2:0];
      residue_in = two_rows ? '0 : (pool[6:0] & next_mask);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         residue_ff <= '0;
         phase_ff <= '0;
         row_ff <= '0;
         acc_ff <= '0;
      end else if (load) begin
         residue_ff <= residue_in;
         phase_ff <= phase_in;
         row_ff <= row_in;
         acc_ff <= acc_in;
      end
   end

endmodule

@@ src/rp2d_out_buffer.sv @@
// Result buffer: holds the up to three code words of one byte and drains
// them one beat per cycle while rsp_ready is high. Depends on rp2d_pkg.
module rp2d_out_buffer (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  rp2d_pkg::batch_type batch,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [7:0]         code_word,
   output logic               is_parity_row,
   output logic               last_of_run,
   output logic               room
);
   import rp2d_pkg::*;

   word_type [MAX_RESULTS-1:0] words_ff;
   logic [MAX_RESULTS-1:0]     parity_ff;
   count_type                  count_ff, count_in;
   logic [1:0]                 head_ff, head_in;
   logic                       take;

   assign rsp_valid = (count_ff != 2'd0);
   assign take = rsp_valid && rsp_ready;
   assign room = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);
   assign code_word = words_ff[head_ff];
   assign is_parity_row = parity_ff[head_ff];
   assign last_of_run = (count_ff == 2'd1);

   always_comb begin
      count_in = count_ff;
      head_in = head_ff;
      if (load) begin
         count_in = batch.count;
         head_in = 2'd0;
      end else if (take) begin
         count_in = count_ff - 2'd1;
         head_in = head_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff <= '0;
      end else begin
         count_ff <= count_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         words_ff <= batch.words;
         parity_ff <= batch.parity;
      end
   end

endmodule

@@ src/seven_bit_repack_2d_parity_encoder_unit.sv @@
// Top level of the 7-bit repacking 2D parity encoder.
// Depends on rp2d_pkg, rp2d_chan_if, rp2d_row_encoder and rp2d_out_buffer.
//
// Usage:
//  req_bus carries one data byte per beat; its bits, MSB first, are cut
//  into 7-bit rows. rsp_bus carries one code word per beat: row bits in
//  7..1 and even parity in bit 0. After every seven data rows a column
//  parity row follows, flagged by is_parity_row. last_of_run marks the
//  final word caused by a byte; each byte gives one to three words.
//  Latency: the first word of a byte is valid the cycle after its beat.
//  Throughput: one word per cycle on rsp_bus while the receiver is ready
//  and bytes keep arriving; a byte holds the output buffer until its last
//  word leaves, and the next byte is taken during the cycle that word
//  leaves, so the number of words each byte gives sets the byte rate.
//  Reset clears the stream state (leftover bits, row count, column parity)
//  and empties the buffer; partial rows stay held until more bytes arrive.
//  When the receiver stalls, the current word holds and req_bus.ready
//  drops once the buffered words of the last byte are not draining.
module seven_bit_repack_2d_parity_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   rp2d_req_if.sink    req_bus,
   rp2d_rsp_if.source  rsp_bus
);
   import rp2d_pkg::*;

   batch_type batch;
   logic      room;
   logic      accept;

   assign req_bus.ready = room;
   assign accept = req_bus.valid && room;

   rp2d_row_encoder u_encoder (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .data_byte (req_bus.data_byte),
      .batch     (batch)
   );

   rp2d_out_buffer u_buffer (
      .clock         (clock),
      .reset         (reset),
      .load          (accept),
      .batch         (batch),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .code_word     (rsp_bus.code_word),
      .is_parity_row (rsp_bus.is_parity_row),
      .last_of_run   (rsp_bus.last_of_run),
      .room          (room)
   );

endmodule

@@ src/rp2d_checker.sv @@
// Port-level checks for the 2D parity encoder, bound to the top level.
// Depends on seven_bit_repack_2d_parity_encoder_unit and rp2d_chan_if.
module rp2d_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] code_word,
   input logic       is_parity_row,
   input logic       last_of_run
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (^code_word == 1'b0))
      else $error("code word with odd parity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(code_word)
         && $stable(is_parity_row) && $stable(last_of_run))
      else $error("stalled result beat changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && is_parity_row |=>
         !(rsp_valid && is_parity_row && !$past(last_of_run)))
      else $error("two parity rows within one byte");

endmodule

bind seven_bit_repack_2d_parity_encoder_unit rp2d_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .code_word     (rsp_bus.code_word),
   .is_parity_row (rsp_bus.is_parity_row),
   .last_of_run   (rsp_bus.last_of_run)
);
